@@ hw/rtl/pqm_pkg.sv @@
// Package for the max-first priority queue: entry and command types,
// operation and status codes, and default sizes.
// No dependencies; imported by pqm_cell and priority_queue_max_fifo_ties_core.
package pqm_pkg;

  // Default number of cells in the chain.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  // Field widths of the request and result.
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried in the request.
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // Status codes returned in the result.
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // One stored pair.
  typedef struct packed {
    logic signed [DATA_W-1:0] prio;
    logic signed [DATA_W-1:0] value;
  } pqm_entry_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } pqm_cmd_t;

endpackage

@@ hw/rtl/priority_queue_max_fifo_ties_core.sv @@
// Top level of the max-first priority queue: stream ports, occupancy count,
// result register and the chain of pqm_cell instances.
// Depends on pqm_pkg and pqm_cell.
//
//  Port group | Direction | Contents (lowest bit first)
//  s_*        | in        | tuser: func; tdata: item_value, item_priority
//  m_*        | out       | tdata: popped_value, status, entry_count, is_empty
//
// One request is taken per cycle while the result slot is free or being
// emptied; its result appears in the output register on the next cycle.
// The chain sorts on insertion and shifts up on removal, all cells at once.
// rst is synchronous and empties the queue and the output register.
// A stalled result holds the input off only while it cannot be replaced.
module priority_queue_max_fifo_ties_core #(
  parameter int unsigned QUEUE_DEPTH = pqm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] item_value, [63:32] item_priority
  input  logic [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] popped_value, [33:32] status,
                                 // [38:34] entry_count, [39] is_empty
);
  import pqm_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              accept;
  logic [FUNC_W-1:0] func;
  pqm_entry_t        new_entry;
  pqm_cmd_t          cmd;
  logic              is_full;
  logic              is_none;

  pqm_entry_t        entries [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valids;
  logic [QUEUE_DEPTH-1:0] keeps;

  logic [DATA_W-1:0]   popped_next;
  logic [STATUS_W-1:0] status_next;
  logic [CW+COUNT_W-1:0] count_ext;

  // Handshake: a new request may enter whenever the result slot is free or
  // is being emptied in the same cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign func            = s_tuser;
  assign new_entry.value = s_tdata[31:0];
  assign new_entry.prio  = s_tdata[63:32];

  assign is_full = (count == CW'(QUEUE_DEPTH));
  assign is_none = (count == '0);

  // Command decode; a push onto a full queue and a pop of an empty one are
  // not passed to the chain.
  always_comb begin
    cmd = '0;
    if (accept) begin
      case (func)
        FUNC_PUSH:  cmd.push = !is_full;
        FUNC_POP:   cmd.pop  = !is_none;
        FUNC_CLEAR: cmd.clr  = 1'b1;
        default:    cmd      = '0;
      endcase
    end
  end

  // Next occupancy and result fields.
  always_comb begin
    count_next  = count;
    popped_next = '0;
    status_next = STATUS_OK;
    case (func)
      FUNC_PUSH: begin
        if (is_full) status_next = STATUS_FULL;
        else         count_next  = count + CW'(1);
      end
      FUNC_POP: begin
        if (is_none) begin
          status_next = STATUS_EMPTY;
        end else begin
          count_next  = count - CW'(1);
          popped_next = entries[0].value;
        end
      end
      FUNC_CLEAR: count_next = '0;
      default:    count_next = count;
    endcase
  end

  // Occupancy register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result register: valid flag under reset, payload loaded on accept.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {(count_next == '0), count_ext[COUNT_W-1:0], status_next, popped_next};
    end
  end

  // The chain: cell 0 holds the entry to be served next.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pqm_entry_t prev_e;
    pqm_entry_t next_e;
    logic       prev_v;
    logic       prev_k;
    logic       next_v;

    if (i == 0) begin : g_head
      assign prev_e = new_entry;
      assign prev_v = 1'b0;
      assign prev_k = 1'b1;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_v = valids[i-1];
      assign prev_k = keeps[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_e = new_entry;
      assign next_v = 1'b0;
    end else begin : g_mid
      assign next_e = entries[i+1];
      assign next_v = valids[i+1];
    end

    pqm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_valid (prev_v),
      .prev_keep  (prev_k),
      .next_entry (next_e),
      .next_valid (next_v),
      .entry      (entries[i]),
      .valid      (valids[i]),
      .keep       (keeps[i])
    );
  end

  // The count never exceeds the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // The count matches the number of occupied cells.
  a_count_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valids) == int'(count))
    else $error("occupancy disagrees with cell valid bits");

  // A clear leaves the queue empty.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && func == FUNC_CLEAR) |=> (count == '0 && valids == '0))
    else $error("queue not empty after clear");

  // Occupied cells are packed at the head and ordered by priority.
  for (genvar j = 0; j + 1 < QUEUE_DEPTH; j++) begin : g_order
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      valids[j+1] |-> (valids[j] && !(entries[j+1].prio > entries[j].prio)))
      else $error("chain out of priority order");
  end

endmodule

@@ hw/rtl/pqm_cell.sv @@
// One cell of the sorted chain: holds a single entry and its valid bit.
// Depends on pqm_pkg for the entry and command types.
module pqm_cell (
  input  logic             clk,
  input  logic             rst,
  input  pqm_pkg::pqm_cmd_t   cmd,
  input  pqm_pkg::pqm_entry_t new_entry,
  input  pqm_pkg::pqm_entry_t prev_entry,
  input  logic             prev_valid,
  input  logic             prev_keep,
  input  pqm_pkg::pqm_entry_t next_entry,
  input  logic             next_valid,
  output pqm_pkg::pqm_entry_t entry,
  output logic             valid,
  output logic             keep
);
  import pqm_pkg::*;

  // The cell keeps its entry on a push when it ranks at least as high as the
  // new one; equal priorities stay ahead, which gives first-in order on ties.
  assign keep = valid && !(new_entry.prio > entry.prio);

  // Valid bit: a push either keeps, takes the new entry or takes the
  // neighbour above; a pop shifts everything up by one cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clr) begin
      valid <= 1'b0;
    end else if (cmd.pop) begin
      valid <= next_valid;
    end else if (cmd.push && !keep) begin
      valid <= prev_keep ? 1'b1 : prev_valid;
    end
  end

  // Entry payload follows the same choice.
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      entry <= next_entry;
    end else if (cmd.push && !keep) begin
      entry <= prev_keep ? new_entry : prev_entry;
    end
  end

endmodule
